// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion helper macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALL(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rst, prop)
`define ASSERT_ALL(name, clk, prop)
`endif
`endif

// ===== rtl/core/trq_pkg.sv =====
// ---------------------------------------------------------------------------
// trq_pkg
// types, codes and defaults shared by the timed packet release queue
// ---------------------------------------------------------------------------
package trq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam logic [31:0] IDLE_WAIT_MS  = 32'd50;

  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_REL   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_NOT_DUE  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    K_NONE     = 3'd0,
    K_QUEUED   = 3'd1,
    K_DROPPED  = 3'd2,
    K_RELEASED = 3'd3,
    K_NOT_DUE  = 3'd4,
    K_EMPTY    = 3'd5,
    K_CLEARED  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [15:0] channel_id;
    logic [15:0] socket_id;
    logic [15:0] buffer_handle;
    logic [15:0] payload_length;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [31:0] delay_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_now;
    logic [15:0] out_socket;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic [31:0] wait_ms;
    logic [10:0] removed_count;
    logic [10:0] occupancy;
  } result_t;

  typedef struct packed {
    logic [31:0] release_time;
    logic [15:0] channel;
    logic [15:0] socket;
    logic [15:0] handle;
    logic [15:0] length;
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

  typedef struct packed {
    logic  cap;
    logic  init_enq;
    logic  rd_prev;
    logic  shift;
    logic  ins;
    logic  rd_head;
    logic  pop;
    logic  init_clr;
    logic  rd_cur;
    logic  keep;
    logic  drop;
    logic  clr_done;
    logic  emit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       empty;
    logic       idx_zero;
    logic       later;
    logic       due;
    logic       chan_match;
    logic       scan_done;
    logic       out_busy;
  } stat_t;

endpackage

// ===== rtl/core/trq_ctrl.sv =====
// ---------------------------------------------------------------------------
// trq_ctrl
// sequencer for enqueue, release and clear requests
// ---------------------------------------------------------------------------
module trq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  trq_pkg::stat_t  stat,
  output trq_pkg::cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_HEAD_CMP = 9'b000000100,
    S_ENQ_CHK  = 9'b000001000,
    S_ENQ_CMP  = 9'b000010000,
    S_CLR_CHK  = 9'b000100000,
    S_CLR_CMP  = 9'b001000000,
    S_DONE     = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t          state, state_next;
  trq_pkg::kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= trq_pkg::K_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.kind   = kind;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          trq_pkg::FUNC_ENQ: begin
            if (stat.full) begin
              kind_next  = trq_pkg::K_DROPPED;
              state_next = S_DONE;
            end else begin
              cmd.init_enq = 1'b1;
              state_next   = S_ENQ_CHK;
            end
          end
          trq_pkg::FUNC_REL: begin
            if (stat.empty) begin
              kind_next  = trq_pkg::K_EMPTY;
              state_next = S_DONE;
            end else begin
              cmd.rd_head = 1'b1;
              state_next  = S_HEAD_CMP;
            end
          end
          trq_pkg::FUNC_CLEAR: begin
            cmd.init_clr = 1'b1;
            state_next   = S_CLR_CHK;
          end
          default: begin
            kind_next  = trq_pkg::K_NONE;
            state_next = S_DONE;
          end
        endcase
      end
      S_HEAD_CMP: begin
        if (stat.due) begin
          cmd.pop   = 1'b1;
          kind_next = trq_pkg::K_RELEASED;
        end else begin
          kind_next = trq_pkg::K_NOT_DUE;
        end
        state_next = S_DONE;
      end
      S_ENQ_CHK: begin
        if (stat.idx_zero) begin
          cmd.ins    = 1'b1;
          kind_next  = trq_pkg::K_QUEUED;
          state_next = S_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        if (stat.later) begin
          cmd.shift  = 1'b1;
          state_next = S_ENQ_CHK;
        end else begin
          cmd.ins    = 1'b1;
          kind_next  = trq_pkg::K_QUEUED;
          state_next = S_DONE;
        end
      end
      S_CLR_CHK: begin
        if (stat.scan_done) begin
          cmd.clr_done = 1'b1;
          kind_next    = trq_pkg::K_CLEARED;
          state_next   = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_CLR_CMP;
        end
      end
      S_CLR_CMP: begin
        if (stat.chan_match) begin
          cmd.drop = 1'b1;
        end else begin
          cmd.keep = 1'b1;
        end
        state_next = S_CLR_CHK;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/trq_dp.sv =====
// ---------------------------------------------------------------------------
// trq_dp
// descriptor store as a sorted ring, indices, result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trq_dp #(
  parameter int unsigned QUEUE_DEPTH = trq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  trq_pkg::item_t    req,
  input  trq_pkg::cmd_t     cmd,
  output trq_pkg::stat_t    stat,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output trq_pkg::result_t  rsp
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

  trq_pkg::entry_t  mem [QUEUE_DEPTH];
  trq_pkg::entry_t  rdata;
  trq_pkg::entry_t  wdata;
  trq_pkg::item_t   cur;
  trq_pkg::result_t rsp_next;
  logic [31:0]      rt;
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    wptr;
  logic [CW-1:0]    removed;
  logic [AW-1:0]    raddr, waddr;
  logic             re, we;
  logic [CW+10:0]   occ_ext, rem_ext;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(l);
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    re    = cmd.rd_prev | cmd.rd_head | cmd.rd_cur;
    we    = cmd.shift | cmd.ins | cmd.keep;
    raddr = head;
    if (cmd.rd_prev) begin
      raddr = phys(head, idx - CW'(1));
    end else if (cmd.rd_cur) begin
      raddr = phys(head, idx);
    end
    waddr = cmd.keep ? phys(head, wptr) : phys(head, idx);
    if (cmd.ins) begin
      wdata.release_time = rt;
      wdata.channel      = cur.channel_id;
      wdata.socket       = cur.socket_id;
      wdata.handle       = cur.buffer_handle;
      wdata.length       = cur.payload_length;
      wdata.addr         = cur.dest_addr;
      wdata.port         = cur.dest_port;
    end else begin
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur <= req;
      rt  <= req.now_ms + req.delay_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      idx     <= '0;
      wptr    <= '0;
      removed <= '0;
    end else begin
      if (cmd.init_enq) begin
        idx <= count;
      end
      if (cmd.shift) begin
        idx <= idx - CW'(1);
      end
      if (cmd.ins) begin
        count <= count + CW'(1);
      end
      if (cmd.pop) begin
        head  <= phys(head, CW'(1));
        count <= count - CW'(1);
      end
      if (cmd.init_clr) begin
        idx     <= '0;
        wptr    <= '0;
        removed <= '0;
      end
      if (cmd.keep) begin
        wptr <= wptr + CW'(1);
        idx  <= idx + CW'(1);
      end
      if (cmd.drop) begin
        removed <= removed + CW'(1);
        idx     <= idx + CW'(1);
      end
      if (cmd.clr_done) begin
        count <= wptr;
      end
    end
  end

  always_comb begin
    stat.func       = cur.func;
    stat.full       = (count >= CW'(QUEUE_DEPTH));
    stat.empty      = (count == '0);
    stat.idx_zero   = (idx == '0);
    stat.later      = (rdata.release_time > rt);
    stat.due        = (rdata.release_time <= cur.now_ms);
    stat.chan_match = (rdata.channel == cur.channel_id);
    stat.scan_done  = (idx == count);
    stat.out_busy   = rsp_valid & ~rsp_ready;
  end

  assign occ_ext = {11'b0, count};
  assign rem_ext = {11'b0, removed};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp_next           = '0;
    rsp_next.occupancy = occ_ext[10:0];
    case (cmd.kind)
      trq_pkg::K_QUEUED:  rsp_next.status = trq_pkg::ST_QUEUED;
      trq_pkg::K_DROPPED: rsp_next.status = trq_pkg::ST_DROPPED;
      trq_pkg::K_RELEASED: begin
        rsp_next.status     = trq_pkg::ST_RELEASED;
        rsp_next.send_now   = (rdata.addr != '0) && (rdata.port != '0);
        rsp_next.out_socket = rdata.socket;
        rsp_next.out_handle = rdata.handle;
        rsp_next.out_length = rdata.length;
        rsp_next.out_addr   = rdata.addr;
        rsp_next.out_port   = rdata.port;
      end
      trq_pkg::K_NOT_DUE: begin
        rsp_next.status  = trq_pkg::ST_NOT_DUE;
        rsp_next.wait_ms = rdata.release_time - cur.now_ms;
      end
      trq_pkg::K_EMPTY: begin
        rsp_next.status  = trq_pkg::ST_NOT_DUE;
        rsp_next.wait_ms = trq_pkg::IDLE_WAIT_MS;
      end
      trq_pkg::K_CLEARED: begin
        rsp_next.status        = trq_pkg::ST_CLEARED;
        rsp_next.removed_count = rem_ext[10:0];
      end
      default: rsp_next.status = trq_pkg::ST_NOT_DUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_RST(a_count_bound, clk, rst, count <= CW'(QUEUE_DEPTH))
  `ASSERT_RST(a_emit_free, clk, rst, cmd.emit |-> !stat.out_busy)
  `ASSERT_RST(a_ins_not_full, clk, rst, cmd.ins |-> !stat.full)
  `ASSERT_RST(a_pop_count, clk, rst, cmd.pop |=> (count == $past(count) - CW'(1)))

endmodule

// ===== rtl/core/timed_packet_release_queue.sv =====
// ---------------------------------------------------------------------------
// timed_packet_release_queue
// holds packet descriptors ordered by release time, releases due ones
// ---------------------------------------------------------------------------
//  channel   dir  handshake               beat
//  req       in   req_valid / req_ready   trq_pkg::item_t
//  rsp       out  rsp_valid / rsp_ready   trq_pkg::result_t
//
//  release reads and compares the head; an empty queue, a full queue on
//  enqueue or an unused func skips the store. enqueue moves each entry with
//  a later release time back one slot, then writes the new one; clear drops
//  the entries of the channel and compacts the rest. one request at a time;
//  the next is taken once the result is registered. reset clears pointers,
//  counts and rsp_valid, no clearing pass; rsp stalls hold the sequencer.
// ---------------------------------------------------------------------------
module timed_packet_release_queue #(
  parameter int unsigned QUEUE_DEPTH = trq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  trq_pkg::item_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output trq_pkg::result_t  rsp
);

  trq_pkg::cmd_t  cmd;
  trq_pkg::stat_t stat;

  trq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  trq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
